FILE: sv/quadratic_root_solver_macros.svh
// ----------------------------------------------------------------------------
// quadratic root solver assertion macros
// concurrent checks that vanish in synthesis
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QRS_ASSERT_IMPL(lbl, ante, cons, msg)
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types and codes of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

  // case an item falls into as it moves down the pipe
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_INF,
    MODE_LIN,
    MODE_QUAD,
    MODE_ONE,
    MODE_TWO
  } mode_t;

  // root count codes on the output
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  // square root steps (66-bit radicand, two bits a step)
  localparam int SQRT_STEPS = 33;
  // quotient bits below the overflow check
  localparam int QUO_STEPS  = 33;

  // coefficients and case carried beside the discriminant
  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } qrs_item_t;

  // side data of the divider lanes
  typedef struct packed {
    logic [32:0] dmag;
    logic        neg1;
    logic        neg2;
    logic        over1;
    logic        over2;
    logic        dz;
    logic        on2;
    logic [1:0]  cnt;
  } qrs_div_side_t;

  // magnitude of a signed 32-bit word
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? (32'd0 - 32'(v)) : 32'(v);
    return r;
  endfunction

endpackage

FILE: sv/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// coefficient capture, products and discriminant, three stages
// ----------------------------------------------------------------------------
module qrs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] coef_a,
  input  logic signed [31:0] coef_b,
  input  logic signed [31:0] coef_c,
  input  logic [15:0]        tol,
  output logic               out_valid,
  output logic [65:0]        out_d,
  output qrs_pkg::qrs_item_t out_item
);
  import qrs_pkg::*;

  logic        v1, v2, v3;
  qrs_item_t   item1, item2, item3;
  logic [31:0] amag1, bmag1, cmag1;
  logic        acn1, acn2;
  logic [63:0] bb2, p2;
  logic [65:0] d3;

  logic [31:0] amag, bmag, cmag;
  mode_t       mode_in;
  logic [65:0] bb66, p4;
  logic        acn_eff, dneg;
  logic [65:0] d_next;
  mode_t       mode_next;

  // classify on the incoming word
  always_comb begin
    amag = mag32(coef_a);
    bmag = mag32(coef_b);
    cmag = mag32(coef_c);
    if (amag > {16'd0, tol}) begin
      mode_in = MODE_QUAD;
    end else if (bmag > {16'd0, tol}) begin
      mode_in = MODE_LIN;
    end else if (cmag > {16'd0, tol}) begin
      mode_in = MODE_NONE;
    end else begin
      mode_in = MODE_INF;
    end
  end

  // stage 1: capture
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1 <= '{mode: mode_in, a: coef_a, b: coef_b, c: coef_c};
      amag1 <= amag;
      bmag1 <= bmag;
      cmag1 <= cmag;
      acn1  <= coef_a[31] ^ coef_c[31];
    end
  end

  // stage 2: b squared and a times c
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item2 <= item1;
      bb2   <= bmag1 * bmag1;
      p2    <= amag1 * cmag1;
      acn2  <= acn1;
    end
  end

  // discriminant and its case
  always_comb begin
    bb66    = {2'b00, bb2};
    p4      = {p2, 2'b00};
    acn_eff = acn2 && (p2 != 64'd0);
    d_next  = acn_eff ? (bb66 + p4) : (bb66 - p4);
    dneg    = !acn_eff && (p4 > bb66);
    if (item2.mode != MODE_QUAD) begin
      mode_next = item2.mode;
    end else if (dneg) begin
      mode_next = MODE_NONE;
    end else if (d_next[65:32] == 34'd0 && d_next[31:0] <= {tol, 16'h0000}) begin
      mode_next = MODE_ONE;
    end else begin
      mode_next = MODE_TWO;
    end
  end

  // stage 3: discriminant register
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item3 <= '{mode: mode_next, a: item2.a, b: item2.b, c: item2.c};
      d3    <= dneg ? 66'd0 : d_next;
    end
  end

  assign out_valid = v3;
  assign out_d     = d3;
  assign out_item  = item3;

endmodule

FILE: sv/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [65:0]        in_d,
  input  qrs_pkg::qrs_item_t in_item,
  output logic               out_valid,
  output logic [32:0]        out_root,
  output qrs_pkg::qrs_item_t out_item
);
  import qrs_pkg::*;

  logic        st_v    [SQRT_STEPS+1];
  logic [36:0] st_rem  [SQRT_STEPS+1];
  logic [32:0] st_root [SQRT_STEPS+1];
  logic [65:0] st_d    [SQRT_STEPS+1];
  qrs_item_t   st_item [SQRT_STEPS+1];

  assign st_v[0]    = in_valid;
  assign st_rem[0]  = 37'd0;
  assign st_root[0] = 33'd0;
  assign st_d[0]    = in_d;
  assign st_item[0] = in_item;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam int Pos = SQRT_STEPS - 1 - j;
    logic [36:0] rem_sh, trial, rem_new;
    logic [32:0] root_new;

    // bring down the next bit pair and try the trial subtract
    always_comb begin
      rem_sh = {st_rem[j][34:0], st_d[j][2*Pos +: 2]};
      trial  = {2'b00, st_root[j], 2'b01};
      if (rem_sh >= trial) begin
        rem_new  = rem_sh - trial;
        root_new = {st_root[j][31:0], 1'b1};
      end else begin
        rem_new  = rem_sh;
        root_new = {st_root[j][31:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j+1] <= 1'b0;
      end else if (en) begin
        st_v[j+1] <= st_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[j+1]  <= rem_new;
        st_root[j+1] <= root_new;
        st_d[j+1]    <= st_d[j];
        st_item[j+1] <= st_item[j];
      end
    end
  end

  assign out_valid = st_v[SQRT_STEPS];
  assign out_root  = st_root[SQRT_STEPS];
  assign out_item  = st_item[SQRT_STEPS];

endmodule

FILE: sv/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// two-lane pipelined Q16.16 divider with a shared divisor and saturation
// ----------------------------------------------------------------------------
module qrs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [34:0] num1,
  input  logic signed [34:0] num2,
  input  logic signed [33:0] den,
  input  logic               on2,
  input  logic [1:0]         cnt,
  output logic               out_valid,
  output logic [31:0]        root1,
  output logic [31:0]        root2,
  output logic               sat,
  output logic [1:0]         cnt_out
);
  import qrs_pkg::*;

  logic          st_v    [QUO_STEPS+1];
  logic [49:0]   st_rem1 [QUO_STEPS+1];
  logic [49:0]   st_rem2 [QUO_STEPS+1];
  logic [32:0]   st_q1   [QUO_STEPS+1];
  logic [32:0]   st_q2   [QUO_STEPS+1];
  qrs_div_side_t st_side [QUO_STEPS+1];

  logic [34:0]   nm1, nm2;
  logic [33:0]   dm;
  logic [49:0]   n1s, n2s;
  logic [65:0]   dtop;
  qrs_div_side_t side_in;

  logic          o_v, o_sat;
  logic [31:0]   o_r1, o_r2;
  logic [1:0]    o_cnt;
  logic [32:0]   fix1, fix2;

  // scale up, take magnitudes and check for a quotient past 33 bits
  always_comb begin
    nm1  = num1[34] ? (35'd0 - 35'(num1)) : 35'(num1);
    nm2  = num2[34] ? (35'd0 - 35'(num2)) : 35'(num2);
    dm   = den[33] ? (34'd0 - 34'(den)) : 34'(den);
    n1s  = {nm1[33:0], 16'h0000};
    n2s  = {nm2[33:0], 16'h0000};
    dtop = {dm[32:0], 33'd0};
    side_in.dmag  = dm[32:0];
    side_in.neg1  = num1[34] ^ den[33];
    side_in.neg2  = num2[34] ^ den[33];
    side_in.over1 = {16'd0, n1s} >= dtop;
    side_in.over2 = {16'd0, n2s} >= dtop;
    side_in.dz    = (dm == 34'd0);
    side_in.on2   = on2;
    side_in.cnt   = cnt;
  end

  // prep stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (en) begin
      st_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_rem1[0] <= n1s;
      st_rem2[0] <= n2s;
      st_q1[0]   <= 33'd0;
      st_q2[0]   <= 33'd0;
      st_side[0] <= side_in;
    end
  end

  // restoring steps, quotient bit 32 down to bit 0
  for (genvar j = 0; j < QUO_STEPS; j++) begin : g_step
    localparam int Sh = QUO_STEPS - 1 - j;
    logic [65:0] dsh;
    logic        ge1, ge2;

    always_comb begin
      dsh = 66'(st_side[j].dmag) << Sh;
      ge1 = {16'd0, st_rem1[j]} >= dsh;
      ge2 = {16'd0, st_rem2[j]} >= dsh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j+1] <= 1'b0;
      end else if (en) begin
        st_v[j+1] <= st_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem1[j+1] <= ge1 ? (st_rem1[j] - dsh[49:0]) : st_rem1[j];
        st_rem2[j+1] <= ge2 ? (st_rem2[j] - dsh[49:0]) : st_rem2[j];
        st_q1[j+1]   <= {st_q1[j][31:0], ge1};
        st_q2[j+1]   <= {st_q2[j][31:0], ge2};
        st_side[j+1] <= st_side[j];
      end
    end
  end

  // sign and clip a quotient, flag in the top bit; zero for a zero divisor
  function automatic logic [32:0] fix_root(input logic [32:0] q, input logic neg,
                                           input logic over, input logic dz);
    logic [32:0] r;
    if (dz) begin
      r = 33'd0;
    end else if (neg) begin
      if (over || q > 33'h080000000) begin
        r = {1'b1, 32'h80000000};
      end else begin
        r = {1'b0, 32'd0 - q[31:0]};
      end
    end else begin
      if (over || q > 33'h07FFFFFFF) begin
        r = {1'b1, 32'h7FFFFFFF};
      end else begin
        r = {1'b0, q[31:0]};
      end
    end
    return r;
  endfunction

  always_comb begin
    fix1 = fix_root(st_q1[QUO_STEPS], st_side[QUO_STEPS].neg1,
                    st_side[QUO_STEPS].over1, st_side[QUO_STEPS].dz);
    fix2 = fix_root(st_q2[QUO_STEPS], st_side[QUO_STEPS].neg2,
                    st_side[QUO_STEPS].over2, st_side[QUO_STEPS].dz);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en) begin
      o_v <= st_v[QUO_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r1  <= fix1[31:0];
      o_r2  <= st_side[QUO_STEPS].on2 ? fix2[31:0] : 32'd0;
      o_sat <= fix1[32] | (st_side[QUO_STEPS].on2 & fix2[32]);
      o_cnt <= st_side[QUO_STEPS].cnt;
    end
  end

  assign out_valid = o_v;
  assign root1     = o_r1;
  assign root2     = o_r2;
  assign sat       = o_sat;
  assign cnt_out   = o_cnt;

endmodule

FILE: sv/quadratic_root_solver.sv
// throughput: one word per cycle; the 33-step root and 33-step divider stages
//   each take one new word every cycle while the output is free or taken
// reset: rst clears all stage valid bits and sets zero_tolerance to 1
// the whole pipe holds while a result waits and m_tready is low
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c = 0 in signed Q16.16, fully pipelined
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_macros.svh"

module quadratic_root_solver (
  input  logic        clk,
  input  logic        rst,
  // coefficients: coef_a [31:0], coef_b [63:32], coef_c [95:64]
  input  logic [95:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // roots: root_first [31:0], root_second [63:32]
  output logic [63:0] m_tdata,
  // status: root_count [1:0], saturated [2]
  output logic [2:0]  m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // zero_tolerance register
  input  logic [15:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  import qrs_pkg::*;

  logic        adv;
  logic [15:0] tol;

  logic        f_v;
  logic [65:0] f_d;
  qrs_item_t   f_item;

  logic        q_v;
  logic [32:0] q_root;
  qrs_item_t   q_item;

  logic               sel_v, sel_on2;
  logic signed [34:0] sel_n1, sel_n2;
  logic signed [33:0] sel_den;
  logic [1:0]         sel_cnt;

  logic signed [34:0] nb, sx, nc;
  logic signed [33:0] a2, bx;

  logic signed [34:0] n1_next, n2_next;
  logic signed [33:0] den_next;
  logic               on2_next;
  logic [1:0]         cnt_next;

  logic        d_v, d_sat;
  logic [31:0] d_r1, d_r2;
  logic [1:0]  d_cnt;

  // whole pipe moves when the output word is free or taken
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_tvalid),
    .coef_a    ($signed(s_tdata[31:0])),
    .coef_b    ($signed(s_tdata[63:32])),
    .coef_c    ($signed(s_tdata[95:64])),
    .tol       (tol),
    .out_valid (f_v),
    .out_d     (f_d),
    .out_item  (f_item)
  );

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f_v),
    .in_d      (f_d),
    .in_item   (f_item),
    .out_valid (q_v),
    .out_root  (q_root),
    .out_item  (q_item)
  );

  // numerators and divisor per case
  always_comb begin
    nb = 35'sd0 - 35'(q_item.b);
    nc = 35'sd0 - 35'(q_item.c);
    sx = $signed({2'b00, q_root});
    a2 = $signed({q_item.a[31], q_item.a, 1'b0});
    bx = 34'(q_item.b);
    n1_next  = nb - sx;
    n2_next  = nb + sx;
    den_next = 34'sd0;
    on2_next = 1'b0;
    cnt_next = CNT_NONE;
    unique case (q_item.mode)
      MODE_LIN: begin
        n1_next  = nc;
        den_next = bx;
        cnt_next = CNT_ONE;
      end
      MODE_ONE: begin
        n1_next  = nb;
        den_next = a2;
        cnt_next = CNT_ONE;
      end
      MODE_TWO: begin
        den_next = a2;
        on2_next = 1'b1;
        cnt_next = CNT_TWO;
      end
      MODE_INF: begin
        cnt_next = CNT_INF;
      end
      default: begin
        cnt_next = CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_v <= 1'b0;
    end else if (adv) begin
      sel_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_n1  <= n1_next;
      sel_n2  <= n2_next;
      sel_den <= den_next;
      sel_on2 <= on2_next;
      sel_cnt <= cnt_next;
    end
  end

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sel_v),
    .num1      (sel_n1),
    .num2      (sel_n2),
    .den       (sel_den),
    .on2       (sel_on2),
    .cnt       (sel_cnt),
    .out_valid (d_v),
    .root1     (d_r1),
    .root2     (d_r2),
    .sat       (d_sat),
    .cnt_out   (d_cnt)
  );

  assign m_tvalid = d_v;
  assign m_tdata  = {d_r2, d_r1};
  assign m_tuser  = {d_sat, d_cnt};

  // checks
  `QRS_ASSERT_IMPL(a_empty_fields, m_tvalid && (m_tuser[1:0] == CNT_NONE || m_tuser[1:0] == CNT_INF), m_tdata == 64'd0 && !m_tuser[2], "roots present without a root count")
  `QRS_ASSERT_IMPL(a_single_root, m_tvalid && m_tuser[1:0] == CNT_ONE, m_tdata[63:32] == 32'd0, "second root set for a single root")
  `QRS_ASSERT_IMPL(a_free_accept, !m_tvalid, s_tready, "input stalled with an empty output")

endmodule
